>>> hdl/gfc_pkg.sv
// gfc_pkg: shared types, constants and helpers of the gamepad frame conditioner
package gfc_pkg;

    localparam logic [14:0] FULL_SCALE = 15'h7fff;
    localparam logic [14:0] DZ_RESET   = 15'd7864;
    localparam int          ROOT_STEPS = 16;
    localparam int          QUO_BITS   = 16;
    localparam int          NUM_W      = 46;
    localparam int          DEN_W      = 31;

    typedef struct packed {
        logic               pad_ok;
        logic signed [15:0] left_stick_x;
        logic signed [15:0] left_stick_y;
        logic signed [15:0] right_stick_x;
        logic signed [15:0] right_stick_y;
        logic [7:0]         left_trigger_raw;
        logic [7:0]         right_trigger_raw;
        logic [15:0]        button_word;
    } t_in_req;

    typedef struct packed {
        logic               present;
        logic signed [15:0] left_out_x;
        logic signed [15:0] left_out_y;
        logic signed [15:0] right_out_x;
        logic signed [15:0] right_out_y;
        logic [15:0]        right_x_magnitude;
        logic [14:0]        left_trigger_level;
        logic [14:0]        right_trigger_level;
        logic [15:0]        held_buttons;
        logic [15:0]        pressed_buttons;
    } t_out_req;

    typedef struct packed {
        logic               done;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_lane_res;

    // floor(t * 32767 / 255) = 128 t + floor(127 t / 255)
    function automatic logic [14:0] trig_scale(input logic [7:0] t);
        logic [14:0] v;
        logic [15:0] s;
        v = {t, 7'b0} - {7'b0, t};
        s = {1'b0, v} + {9'b0, v[14:8]} + 16'd1;
        return {t, 7'b0} + {7'b0, s[15:8]};
    endfunction

endpackage

>>> hdl/gfc_if.sv
// gfc_if: valid/ready channels for reports in and conditioned frames out
interface gfc_in_if;
    logic             valid;
    logic             ready;
    gfc_pkg::t_in_req req;
    modport source(output valid, output req, input ready);
    modport sink(input valid, input req, output ready);
endinterface

interface gfc_out_if;
    logic              valid;
    logic              ready;
    gfc_pkg::t_out_req req;
    modport source(output valid, output req, input ready);
    modport sink(input valid, input req, output ready);
endinterface

>>> hdl/gamepad_frame_conditioner.sv
// gamepad_frame_conditioner: top level, stick lanes, side fields and output merge
// One report at a time: a request runs from acceptance until its frame enters the
// output register through the 16-step magnitude root and the 16-step bit-serial
// divide of each stick lane (both lanes run side by side). A new request
// is taken once the previous frame has moved to the output register, so up to one
// finished frame may wait downstream while the next report is in work.
module gamepad_frame_conditioner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_dz_we,
    input  logic [14:0] i_dz_wdata,
    gfc_in_if.sink      i_in,
    gfc_out_if.source   o_out
);
    logic               r_busy, r_ovalid;
    logic [14:0]        r_dz;
    logic [15:0]        r_prev;
    gfc_pkg::t_out_req  r_side, r_out, n_out, n_side;
    gfc_pkg::t_lane_res n_left, n_right;
    logic               n_acc, n_load;
    logic [15:0]        n_rmag;

    assign i_in.ready = !r_busy;
    assign n_acc  = i_in.valid && !r_busy;
    assign n_load = r_busy && n_left.done && n_right.done && (!r_ovalid || o_out.ready);
    assign n_rmag = i_in.req.right_stick_x[15] ? 16'(-i_in.req.right_stick_x)
                                               : 16'(i_in.req.right_stick_x);

    gfc_lane u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_acc),
        .i_x     (i_in.req.left_stick_x),
        .i_y     (i_in.req.left_stick_y),
        .i_dz    (r_dz),
        .o_res   (n_left)
    );

    gfc_lane u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_acc),
        .i_x     (i_in.req.right_stick_x),
        .i_y     (i_in.req.right_stick_y),
        .i_dz    (r_dz),
        .o_res   (n_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_dz     <= gfc_pkg::DZ_RESET;
            r_prev   <= '0;
        end else begin
            if (i_dz_we) r_dz <= i_dz_wdata;
            if (n_acc) begin
                r_busy <= 1'b1;
                if (i_in.req.pad_ok) r_prev <= i_in.req.button_word;
            end else if (n_load) begin
                r_busy <= 1'b0;
            end
            if (n_load) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
    end

    // side fields captured with the request, zeroed when the pad is absent
    always_comb begin
        n_side = '0;
        if (i_in.req.pad_ok) begin
            n_side.present             = 1'b1;
            n_side.right_x_magnitude   = n_rmag;
            n_side.left_trigger_level  = gfc_pkg::trig_scale(i_in.req.left_trigger_raw);
            n_side.right_trigger_level = gfc_pkg::trig_scale(i_in.req.right_trigger_raw);
            n_side.held_buttons        = i_in.req.button_word;
            n_side.pressed_buttons     = i_in.req.button_word & ~r_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_acc) r_side <= n_side;
        if (n_load) r_out <= n_out;
    end

    always_comb begin
        n_out = r_side;
        if (r_side.present) begin
            n_out.left_out_x  = n_left.x;
            n_out.left_out_y  = n_left.y;
            n_out.right_out_x = n_right.x;
            n_out.right_out_y = n_right.y;
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.req   = r_out;

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.req.present) |-> (o_out.req.left_out_x == 16'sd0
            && o_out.req.right_out_y == 16'sd0 && o_out.req.held_buttons == 16'd0))
        else $error("absent pad frame carries data");

    a_pressed_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.req.pressed_buttons & ~o_out.req.held_buttons) == 16'd0))
        else $error("pressed button not held");

    a_prev_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_acc && i_in.req.pad_ok) |=> (r_prev == $past(i_in.req.button_word)))
        else $error("previous buttons not updated");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_load |=> (o_out.valid && !r_busy))
        else $error("frame load lost");
endmodule

>>> hdl/gfc_div.sv
// gfc_div: bit-serial restoring divider giving a signed 16-bit axis value
module gfc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [gfc_pkg::NUM_W-1:0]       i_num,
    input  logic [gfc_pkg::DEN_W-1:0]       i_den,
    input  logic                            i_neg,
    output logic                            o_done,
    output logic signed [15:0]              o_q
);
    logic        r_run, r_done, r_neg;
    logic [3:0]  r_cnt;
    logic [30:0] r_rem;
    logic [15:0] r_lo, r_q;
    logic [31:0] n_trial;
    logic        n_fit;

    assign n_trial = {r_rem, r_lo[15]};
    assign n_fit   = n_trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'(gfc_pkg::QUO_BITS - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num[45:16]};
            r_lo  <= i_num[15:0];
            r_q   <= '0;
            r_neg <= i_neg;
        end else if (r_run) begin
            r_rem <= n_fit ? 31'(n_trial - {1'b0, i_den}) : n_trial[30:0];
            r_lo  <= {r_lo[14:0], 1'b0};
            r_q   <= {r_q[14:0], n_fit};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

>>> hdl/gfc_lane.sv
// gfc_lane: one stick lane, magnitude root and radial deadzone scaling
module gfc_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [15:0]  i_x,
    input  logic signed [15:0]  i_y,
    input  logic [14:0]         i_dz,
    output gfc_pkg::t_lane_res  o_res
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SQ    = 8'b0000_0010,
        S_SUM   = 8'b0000_0100,
        S_ROOT  = 8'b0000_1000,
        S_SCALE = 8'b0001_0000,
        S_LOAD  = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state             r_state;
    logic signed [15:0] r_x, r_y;
    logic [31:0]        r_xx, r_yy, r_v, r_res, r_bit;
    logic [3:0]         r_cnt;
    logic [30:0]        r_px, r_py, r_den;
    logic               r_zero;
    logic signed [31:0] n_xx, n_yy;
    logic [31:0]        n_try;
    logic [15:0]        n_m, n_magx, n_magy;
    logic [14:0]        n_mc, n_diff, n_span;
    logic               n_dstart, n_done_x, n_done_y;
    logic signed [15:0] n_qx, n_qy;

    assign n_xx   = r_x * r_x;
    assign n_yy   = r_y * r_y;
    assign n_try  = r_res + r_bit;
    assign n_m    = r_res[15:0];
    assign n_mc   = n_m[15] ? gfc_pkg::FULL_SCALE : n_m[14:0];
    assign n_diff = n_mc - i_dz;
    assign n_span = gfc_pkg::FULL_SCALE - i_dz;
    assign n_magx = r_x[15] ? 16'(-r_x) : 16'(r_x);
    assign n_magy = r_y[15] ? 16'(-r_y) : 16'(r_y);
    assign n_dstart = (r_state == S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE, S_DONE: if (i_start) r_state <= S_SQ;
                S_SQ:    r_state <= S_SUM;
                S_SUM: begin
                    r_cnt   <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(gfc_pkg::ROOT_STEPS - 1)) r_state <= S_SCALE;
                end
                S_SCALE: r_state <= S_LOAD;
                S_LOAD:  r_state <= S_DIV;
                S_DIV:   if (n_done_x && n_done_y) r_state <= S_DONE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == S_IDLE || r_state == S_DONE)) begin
            r_x <= i_x;
            r_y <= i_y;
        end
        if (r_state == S_SQ) begin
            r_xx <= 32'(n_xx);
            r_yy <= 32'(n_yy);
        end
        if (r_state == S_SUM) begin
            r_v   <= r_xx + r_yy;
            r_res <= '0;
            r_bit <= 32'h4000_0000;
        end
        if (r_state == S_ROOT) begin
            if (r_v >= n_try) begin
                r_v   <= r_v - n_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (r_state == S_SCALE) begin
            r_px   <= {15'b0, n_magx} * {16'b0, n_diff};
            r_py   <= {15'b0, n_magy} * {16'b0, n_diff};
            r_den  <= {16'b0, n_span} * {15'b0, n_m};
            r_zero <= (n_m <= {1'b0, i_dz}) || (i_dz == gfc_pkg::FULL_SCALE);
        end
    end

    gfc_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_dstart),
        .i_num   ({r_px, 15'b0} - {15'b0, r_px}),
        .i_den   (r_den),
        .i_neg   (r_x[15]),
        .o_done  (n_done_x),
        .o_q     (n_qx)
    );

    gfc_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_dstart),
        .i_num   ({r_py, 15'b0} - {15'b0, r_py}),
        .i_den   (r_den),
        .i_neg   (r_y[15]),
        .o_done  (n_done_y),
        .o_q     (n_qy)
    );

    assign o_res.done = (r_state == S_DONE);
    assign o_res.x    = r_zero ? 16'sd0 : n_qx;
    assign o_res.y    = r_zero ? 16'sd0 : n_qy;
endmodule

>>> dv/tb.sv
// tb: self-checking testbench of the gamepad frame conditioner with its own frame predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 45;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_dz_we = 1'b0;
    logic [14:0] i_dz_wdata = '0;

    gfc_in_if  in_if();
    gfc_out_if out_if();

    gamepad_frame_conditioner u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dz_we   (i_dz_we),
        .i_dz_wdata(i_dz_wdata),
        .i_in      (in_if.sink),
        .o_out     (out_if.source)
    );

    logic [14:0]       dead_zone_model;
    logic [15:0]       last_held;
    gfc_pkg::t_out_req frame_queue[$];
    int                fails;
    int                cycles = 0;
    bit                calm;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic longint root_floor(longint v);
        longint r;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            if ((r | (longint'(1) << b)) * (r | (longint'(1) << b)) <= v) begin
                r = r | (longint'(1) << b);
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] shaped_axis(longint raw, longint m, longint mc, longint dz);
        longint mag;
        longint q;
        mag = raw < 0 ? -raw : raw;
        q = (mag * (mc - dz) * 32767) / ((32767 - dz) * m);
        if (raw < 0) begin
            q = -q;
        end
        return q[15:0];
    endfunction

    task automatic shape_stick(input logic signed [15:0] x, input logic signed [15:0] y,
                               output logic [15:0] ox, output logic [15:0] oy);
        longint m;
        longint mc;
        longint dz;
        dz = dead_zone_model;
        m = root_floor(longint'(x) * x + longint'(y) * y);
        mc = m > 32767 ? 32767 : m;
        if (m <= dz || dz >= 32767) begin
            ox = '0;
            oy = '0;
        end else begin
            ox = shaped_axis(x, m, mc, dz);
            oy = shaped_axis(y, m, mc, dz);
        end
    endtask

    task automatic predict_frame(input gfc_pkg::t_in_req r);
        gfc_pkg::t_out_req f;
        logic [15:0] ax;
        logic [15:0] ay;
        int rx;
        f = '0;
        if (r.pad_ok) begin
            f.present = 1'b1;
            shape_stick(r.left_stick_x, r.left_stick_y, ax, ay);
            f.left_out_x = ax;
            f.left_out_y = ay;
            shape_stick(r.right_stick_x, r.right_stick_y, ax, ay);
            f.right_out_x = ax;
            f.right_out_y = ay;
            rx = r.right_stick_x;
            f.right_x_magnitude = 16'(rx < 0 ? -rx : rx);
            f.left_trigger_level = 15'((int'(r.left_trigger_raw) * 32767) / 255);
            f.right_trigger_level = 15'((int'(r.right_trigger_raw) * 32767) / 255);
            f.held_buttons = r.button_word;
            f.pressed_buttons = r.button_word & ~last_held;
            last_held = r.button_word;
        end
        frame_queue.push_back(f);
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        gfc_pkg::t_out_req e;
        gfc_pkg::t_out_req a;
        if (i_rst_n) begin
            out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
        end else begin
            out_if.ready <= 1'b0;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            a = out_if.req;
            if (frame_queue.size() == 0) begin
                $error("frame with no request waiting");
                fails++;
            end else begin
                e = frame_queue.pop_front();
                check_field("present", e.present, a.present);
                check_field("left_out_x", e.left_out_x, a.left_out_x);
                check_field("left_out_y", e.left_out_y, a.left_out_y);
                check_field("right_out_x", e.right_out_x, a.right_out_x);
                check_field("right_out_y", e.right_out_y, a.right_out_y);
                check_field("right_x_magnitude", e.right_x_magnitude, a.right_x_magnitude);
                check_field("left_trigger_level", e.left_trigger_level, a.left_trigger_level);
                check_field("right_trigger_level", e.right_trigger_level, a.right_trigger_level);
                check_field("held_buttons", e.held_buttons, a.held_buttons);
                check_field("pressed_buttons", e.pressed_buttons, a.pressed_buttons);
            end
        end
    end

    task automatic send_report(input gfc_pkg::t_in_req r);
        if (!calm && $urandom_range(99) < 23) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 23);
        end
        in_if.valid <= 1'b1;
        in_if.req <= r;
        do @(posedge i_clk); while (!in_if.ready);
        predict_frame(r);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (frame_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dead_zone(input logic [14:0] dz);
        wait_drained();
        i_dz_we <= 1'b1;
        i_dz_wdata <= dz;
        @(posedge i_clk);
        i_dz_we <= 1'b0;
        dead_zone_model = dz;
    endtask

    function automatic gfc_pkg::t_in_req make_report(logic ok, int lx, int ly, int rx, int ry,
                                                     int lt, int rt, int btn);
        gfc_pkg::t_in_req r;
        r.pad_ok = ok;
        r.left_stick_x = 16'(lx);
        r.left_stick_y = 16'(ly);
        r.right_stick_x = 16'(rx);
        r.right_stick_y = 16'(ry);
        r.left_trigger_raw = 8'(lt);
        r.right_trigger_raw = 8'(rt);
        r.button_word = 16'(btn);
        return r;
    endfunction

    function automatic logic [15:0] pick_axis();
        int dz;
        dz = dead_zone_model;
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 16'sd32767 : -16'sd32768;
            1: return 16'($urandom_range(200) - 100);
            2: return 16'($urandom_range(1) ? dz + $urandom_range(6) - 3
                                            : -dz + $urandom_range(6) - 3);
            3: return 16'(($urandom_range(1) ? 1 : -1) * int'($urandom_range(dz + 2000)));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic gfc_pkg::t_in_req random_report(logic [15:0] btn_prev);
        logic [15:0] btn;
        case ($urandom_range(3))
            0: btn = btn_prev;
            1: btn = btn_prev ^ (16'd1 << $urandom_range(15));
            default: btn = 16'($urandom);
        endcase
        return make_report($urandom_range(99) >= 8, pick_axis(), pick_axis(), pick_axis(),
                           pick_axis(), $urandom_range(255), $urandom_range(255), btn);
    endfunction

    task automatic test_directed();
        send_report(make_report(1, 0, 0, 0, 0, 0, 0, 16'h0000));
        send_report(make_report(1, 32767, 0, -32768, 0, 255, 255, 16'hffff));
        send_report(make_report(1, -32768, -32768, 32767, 32767, 1, 254, 16'hffff));
        send_report(make_report(0, 1000, 2000, 3000, 4000, 128, 64, 16'h00ff));
        send_report(make_report(1, 7864, 0, 0, -7864, 0, 255, 16'h0f0f));
        send_report(make_report(1, 7865, 0, 0, -7865, 127, 128, 16'hf0f0));
        send_report(make_report(1, 5561, 5561, -5561, 5560, 3, 4, 16'h8001));
        send_report(make_report(0, 0, 0, 0, 0, 0, 0, 16'h0000));
        send_report(make_report(1, -1, 1, 1, -1, 255, 0, 16'h8001));
        send_report(make_report(1, -32768, 32767, 23170, -23170, 2, 253, 16'h5555));
        send_report(make_report(1, 12345, -23456, -30000, 20000, 200, 100, 16'haaaa));
        send_report(make_report(1, 32767, 32767, -32768, -32768, 255, 255, 16'hffff));
    endtask

    task automatic test_dead_zone_extremes();
        logic [14:0] zones[6] = '{15'd0, 15'd1, 15'd32766, 15'd32767, 15'd16384,
                                  gfc_pkg::DZ_RESET};
        foreach (zones[i]) begin
            write_dead_zone(zones[i]);
            send_report(make_report(1, 32767, 0, -32768, -32768, 0, 255, 16'h1234));
            send_report(make_report(1, 1, 0, 0, -1, 10, 20, 16'h4321));
            send_report(make_report(1, zones[i], 0, -int'(zones[i]) - 1, 0, 5, 6, 16'hffff));
        end
    endtask

    task automatic test_random_frames(input int count, input bit quiet);
        gfc_pkg::t_in_req r;
        calm = quiet;
        r = '0;
        repeat (count) begin
            r = random_report(r.button_word);
            send_report(r);
        end
        calm = 1'b0;
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.req = '0;
        dead_zone_model = gfc_pkg::DZ_RESET;
        last_held = '0;
        fails = 0;
        calm = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_dead_zone_extremes();
        test_random_frames(300, 1'b0);
        write_dead_zone(15'd0);
        test_random_frames(250, 1'b1);
        write_dead_zone(15'd32766);
        test_random_frames(200, 1'b0);
        write_dead_zone(15'($urandom_range(32767)));
        test_random_frames(300, 1'b0);
        write_dead_zone(15'd32767);
        test_random_frames(100, 1'b0);
        write_dead_zone(15'd300);
        test_random_frames(250, 1'b0);

        wait_drained();
        if (frame_queue.size() != 0) begin
            $error("%0d frames never arrived", frame_queue.size());
            fails++;
        end
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
